// ===== sv/lfm_pkg.sv =====
package lfm_pkg;

	localparam int LFM_COS_TABLE_DEPTH = 1024;
	localparam int LFM_FRAC_BITS       = 16;

	// Multiplier constants of the integer hash
	localparam logic [31:0] HASH_K1 = 32'h7FEB352D;
	localparam logic [31:0] HASH_K2 = 32'h846CA68B;

	// Unity in Q1.16
	localparam logic [16:0] Q16_ONE = 17'd65536;

	// pi in Q30 and one in Q30, used to build the raised-cosine ROM
	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam longint      ONE_Q30 = 64'sd1073741824;

	// Configuration register indexes
	localparam logic [2:0] REG_ANIM_MODE    = 3'd0;
	localparam logic [2:0] REG_RATE_SCALE   = 3'd1;
	localparam logic [2:0] REG_PHASE_OFFSET = 3'd2;
	localparam logic [2:0] REG_DEPTH        = 3'd3;
	localparam logic [2:0] REG_BASE_RED     = 3'd4;
	localparam logic [2:0] REG_BASE_GREEN   = 3'd5;
	localparam logic [2:0] REG_BASE_BLUE    = 3'd6;

	// Animation modes; the unused code behaves as steady
	localparam logic [1:0] MODE_STEADY  = 2'd0;
	localparam logic [1:0] MODE_FLICKER = 2'd1;
	localparam logic [1:0] MODE_PULSE   = 2'd2;

	typedef struct packed {
		logic [1:0]  anim_mode;
		logic [15:0] rate_scale;
		logic [31:0] phase_offset;
		logic [16:0] depth;
		logic [15:0] base_red;
		logic [15:0] base_green;
		logic [15:0] base_blue;
	} lfm_cfg_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [16:0] factor;
	} lfm_result_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_PH,
		S_PH2,
		S_HA,
		S_HB,
		S_HC,
		S_SQ,
		S_SM,
		S_NA,
		S_NB,
		S_NC,
		S_RI,
		S_RA,
		S_RD,
		S_FAC,
		S_FCT,
		S_RED,
		S_GRN,
		S_BLU
	} lfm_state_t;

endpackage

// ===== sv/light_flicker_modulator.sv =====
// Light flicker modulator: scales an authored RGB colour by a brightness factor
// that is steady, value-noise flicker or a raised-cosine pulse.
// Configuration: write the register index and data on cfg_index/cfg_data with
// cfg_valid; cfg_ready is always high, so each cycle with cfg_valid is a transfer.
// Write only while no tick is in progress.
// Tick channel: one transfer of time_step per frame (tick_valid high, tick_stall
// low). The time accumulator advances and one result follows.
// Result channel: red_out, green_out, blue_out and brightness_factor, held in an
// output register under res_valid until a cycle with res_stall low.
// All multiplications go one at a time through a single registered 32x32
// multiplier. tick_stall stays high from the transfer until the result enters
// the output register, so a new tick is not taken before the last result
// has been loaded there.
// If the receiver stalls, the finished result waits in the output register and a
// further result waits in the sequencer until the register empties.
// Reset clears the time accumulator, the configuration to its defaults, the
// result valid flag and the sequencer state; the pulse table is a constant ROM and needs no fill.
module light_flicker_modulator
	import lfm_pkg::*;
#(
	parameter int COS_TABLE_DEPTH = LFM_COS_TABLE_DEPTH,
	parameter int FRAC_BITS       = LFM_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        tick_valid,
	output logic        tick_stall,
	input  logic [15:0] time_step,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [15:0] red_out,
	output logic [15:0] green_out,
	output logic [15:0] blue_out,
	output logic [16:0] brightness_factor
);

	localparam int AW = $clog2(COS_TABLE_DEPTH);

	lfm_cfg_t    cfg_q;
	lfm_result_t res_w;
	logic        seq_idle, tick_take, out_free, res_load, res_valid_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;
	logic [AW-1:0] rom_addr;
	logic [16:0] rom_data_q;
	logic [15:0] red_q, green_q, blue_q;
	logic [16:0] factor_q;

	assign cfg_ready  = 1'b1;
	assign tick_stall = !seq_idle;
	assign tick_take  = tick_valid && !tick_stall;
	assign out_free   = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.anim_mode    <= MODE_STEADY;
			cfg_q.rate_scale   <= 16'd256;
			cfg_q.phase_offset <= 32'd0;
			cfg_q.depth        <= 17'd0;
			cfg_q.base_red     <= 16'd0;
			cfg_q.base_green   <= 16'd0;
			cfg_q.base_blue    <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ANIM_MODE:    cfg_q.anim_mode    <= cfg_data[1:0];
				REG_RATE_SCALE:   cfg_q.rate_scale   <= cfg_data[15:0];
				REG_PHASE_OFFSET: cfg_q.phase_offset <= cfg_data;
				REG_DEPTH:        cfg_q.depth        <= cfg_data[16:0];
				REG_BASE_RED:     cfg_q.base_red     <= cfg_data[15:0];
				REG_BASE_GREEN:   cfg_q.base_green   <= cfg_data[15:0];
				REG_BASE_BLUE:    cfg_q.base_blue    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			red_q    <= res_w.red;
			green_q  <= res_w.green;
			blue_q   <= res_w.blue;
			factor_q <= res_w.factor;
		end
	end

	assign res_valid         = res_valid_q;
	assign red_out           = red_q;
	assign green_out         = green_q;
	assign blue_out          = blue_q;
	assign brightness_factor = factor_q;

	lfm_seq #(
		.COS_TABLE_DEPTH (COS_TABLE_DEPTH),
		.FRAC_BITS       (FRAC_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.tick_take (tick_take),
		.time_step (time_step),
		.idle      (seq_idle),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res_w),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.prod      (prod_q),
		.rom_addr  (rom_addr),
		.rom_data  (rom_data_q)
	);

	lfm_mul u_mul (
		.clk    (clk),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.prod_q (prod_q)
	);

	lfm_pulse_rom #(
		.COS_TABLE_DEPTH (COS_TABLE_DEPTH)
	) u_rom (
		.clk        (clk),
		.rom_addr   (rom_addr),
		.rom_data_q (rom_data_q)
	);

endmodule

// ===== sv/lfm_mul.sv =====
module lfm_mul
	import lfm_pkg::*;
(
	input  logic        clk,
	input  logic [31:0] mul_a,
	input  logic [31:0] mul_b,
	output logic [63:0] prod_q
);

	// The single shared multiplier; its product is always registered.
	always_ff @(posedge clk) begin
		prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
	end

endmodule

// ===== sv/lfm_pulse_rom.sv =====
module lfm_pulse_rom
	import lfm_pkg::*;
#(
	parameter int COS_TABLE_DEPTH = LFM_COS_TABLE_DEPTH,
	localparam int AW = $clog2(COS_TABLE_DEPTH)
) (
	input  logic          clk,
	input  logic [AW-1:0] rom_addr,
	output logic [16:0]   rom_data_q
);

	// sin^2(pi*k/D) in Q1.16, from a truncated Q30 Taylor series of the sine.
	function automatic logic [16:0] rom_entry(input int unsigned k);
		logic [63:0] kk;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] s;
		longint      sum;
		kk = 64'(k);
		if (64'(COS_TABLE_DEPTH) - kk < kk)
			kk = 64'(COS_TABLE_DEPTH) - kk;
		a = (PI_Q30 * kk) / COS_TABLE_DEPTH;
		a2 = (a * a) >> 30;
		term = a;
		sum = longint'(a);
		term = ((term * a2) >> 30) / 64'd6;
		sum = sum - longint'(term);
		term = ((term * a2) >> 30) / 64'd20;
		sum = sum + longint'(term);
		term = ((term * a2) >> 30) / 64'd42;
		sum = sum - longint'(term);
		term = ((term * a2) >> 30) / 64'd72;
		sum = sum + longint'(term);
		term = ((term * a2) >> 30) / 64'd110;
		sum = sum - longint'(term);
		term = ((term * a2) >> 30) / 64'd156;
		sum = sum + longint'(term);
		if (sum < 0)
			sum = 0;
		if (sum > ONE_Q30)
			sum = ONE_Q30;
		s = 64'(sum);
		return 17'((s * s) >> 44);
	endfunction

	logic [16:0] rom_w [COS_TABLE_DEPTH];

	for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_rom
		assign rom_w[k] = rom_entry(k);
	end

	always_ff @(posedge clk) begin
		rom_data_q <= rom_w[rom_addr];
	end

endmodule

// ===== sv/lfm_seq.sv =====
module lfm_seq
	import lfm_pkg::*;
#(
	parameter int COS_TABLE_DEPTH = LFM_COS_TABLE_DEPTH,
	parameter int FRAC_BITS       = LFM_FRAC_BITS,
	localparam int AW = $clog2(COS_TABLE_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lfm_cfg_t      cfg,
	input  logic          tick_take,
	input  logic [15:0]   time_step,
	output logic          idle,
	input  logic          out_free,
	output logic          res_load,
	output lfm_result_t   res,
	output logic [31:0]   mul_a,
	output logic [31:0]   mul_b,
	input  logic [63:0]   prod,
	output logic [AW-1:0] rom_addr,
	input  logic [16:0]   rom_data
);

	localparam int SHIFT_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int SHIFT_DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam logic [31:0] FRAC_MASK = (32'd1 << FRAC_BITS) - 32'd1;

	lfm_state_t  state_q, state_d;
	logic [31:0] elapsed_q;
	logic [31:0] phase_q;
	logic        hsel_q;
	logic [23:0] h0_q, h1_q;
	logic [16:0] s_q;
	logic [40:0] acc_q;
	logic [16:0] value_q;
	logic [16:0] factor_q;
	logic [15:0] red_q, green_q;

	logic [31:0] step_w, phase_w, cell_w, hx_w, hx1_w, hx2_w, hfin_w, frac_w;
	logic [15:0] f_w;
	logic [16:0] s_w, d_sat_w, factor_w, noise_w;
	logic [41:0] nsum_w;

	assign step_w  = ({16'd0, time_step} << SHIFT_UP) >> SHIFT_DN;
	assign phase_w = prod[39:8] + cfg.phase_offset;

	// The cell is the floor of the signed phase; the second hash takes the next cell.
	assign cell_w = 32'($signed(phase_q) >>> FRAC_BITS);
	assign hx_w   = hsel_q ? cell_w + 32'd1 : cell_w;
	assign hx1_w  = hx_w ^ (hx_w >> 16);
	assign hx2_w  = prod[31:0] ^ (prod[31:0] >> 15);
	assign hfin_w = prod[31:0] ^ (prod[31:0] >> 16);

	assign frac_w = phase_q & FRAC_MASK;
	assign f_w    = 16'((frac_w >> SHIFT_UP) << SHIFT_DN);

	assign s_w      = prod[32:16];
	assign nsum_w   = {1'b0, acc_q} + {1'b0, prod[40:0]};
	assign noise_w  = 17'(nsum_w >> 24);
	assign d_sat_w  = (cfg.depth > Q16_ONE) ? Q16_ONE : cfg.depth;
	assign factor_w = Q16_ONE - prod[32:16];
	assign rom_addr = prod[16 +: AW];

	assign idle      = (state_q == S_IDLE);
	assign res.red   = red_q;
	assign res.green = green_q;
	assign res.blue  = prod[31:16];
	assign res.factor = factor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			elapsed_q <= 32'd0;
			hsel_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tick_take && state_q == S_IDLE)
				elapsed_q <= elapsed_q + step_w;
			if (state_q == S_PH2)
				hsel_q <= 1'b0;
			else if (state_q == S_HC)
				hsel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_PH2: begin
				phase_q <= phase_w;
				value_q <= 17'd0;
			end
			S_HC: begin
				if (hsel_q)
					h1_q <= hfin_w[23:0];
				else
					h0_q <= hfin_w[23:0];
			end
			S_NA:  s_q      <= s_w;
			S_NB:  acc_q    <= prod[40:0];
			S_NC:  value_q  <= noise_w;
			S_RD:  value_q  <= rom_data;
			S_FCT: factor_q <= factor_w;
			S_RED: red_q    <= prod[31:16];
			S_GRN: green_q  <= prod[31:16];
			default: ;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		mul_a    = 32'd0;
		mul_b    = 32'd0;
		res_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (tick_take)
					state_d = S_PH;
			end
			S_PH: begin
				mul_a   = elapsed_q;
				mul_b   = {16'd0, cfg.rate_scale};
				state_d = S_PH2;
			end
			S_PH2: begin
				if (cfg.anim_mode == MODE_FLICKER)
					state_d = S_HA;
				else if (cfg.anim_mode == MODE_PULSE)
					state_d = S_RI;
				else
					state_d = S_FAC;
			end
			S_HA: begin
				mul_a   = hx1_w;
				mul_b   = HASH_K1;
				state_d = S_HB;
			end
			S_HB: begin
				mul_a   = hx2_w;
				mul_b   = HASH_K2;
				state_d = S_HC;
			end
			S_HC: begin
				state_d = hsel_q ? S_SQ : S_HA;
			end
			S_SQ: begin
				mul_a   = {16'd0, f_w};
				mul_b   = {16'd0, f_w};
				state_d = S_SM;
			end
			S_SM: begin
				mul_a   = {16'd0, prod[31:16]};
				mul_b   = {14'd0, 18'd196608 - {1'b0, f_w, 1'b0}};
				state_d = S_NA;
			end
			S_NA: begin
				mul_a   = {8'd0, h0_q};
				mul_b   = {15'd0, Q16_ONE - s_w};
				state_d = S_NB;
			end
			S_NB: begin
				mul_a   = {8'd0, h1_q};
				mul_b   = {15'd0, s_q};
				state_d = S_NC;
			end
			S_NC: begin
				state_d = S_FAC;
			end
			S_RI: begin
				mul_a   = {16'd0, f_w};
				mul_b   = 32'(COS_TABLE_DEPTH);
				state_d = S_RA;
			end
			S_RA: begin
				state_d = S_RD;
			end
			S_RD: begin
				state_d = S_FAC;
			end
			S_FAC: begin
				mul_a   = {15'd0, d_sat_w};
				mul_b   = {15'd0, value_q};
				state_d = S_FCT;
			end
			S_FCT: begin
				mul_a   = {16'd0, cfg.base_red};
				mul_b   = {15'd0, factor_w};
				state_d = S_RED;
			end
			S_RED: begin
				mul_a   = {16'd0, cfg.base_green};
				mul_b   = {15'd0, factor_q};
				state_d = S_GRN;
			end
			S_GRN: begin
				mul_a   = {16'd0, cfg.base_blue};
				mul_b   = {15'd0, factor_q};
				state_d = S_BLU;
			end
			S_BLU: begin
				// The blue product is reissued so that it holds while the output is full.
				mul_a = {16'd0, cfg.base_blue};
				mul_b = {15'd0, factor_q};
				if (out_free) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== sv/lfm_checker.sv =====
module lfm_checker
	import lfm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [31:0] cfg_data,
	input logic        tick_valid,
	input logic        tick_stall,
	input logic [15:0] time_step,
	input logic        res_valid,
	input logic        res_stall,
	input logic [15:0] red_out,
	input logic [15:0] green_out,
	input logic [15:0] blue_out,
	input logic [16:0] brightness_factor
);

	// A held result must not change until it is transferred.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(red_out) && $stable(green_out)
			&& $stable(blue_out) && $stable(brightness_factor))
		else $error("result changed while stalled");

	// Once a tick is taken the block is busy for at least the next cycle.
	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !tick_stall |=> tick_stall)
		else $error("tick channel open right after a transfer");

	// A new result only appears at the end of a tick's processing.
	a_res_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(tick_stall))
		else $error("result appeared without a tick in progress");

	// The factor never exceeds unity.
	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> brightness_factor <= Q16_ONE)
		else $error("brightness factor above unity");

endmodule

bind light_flicker_modulator lfm_checker u_lfm_checker (.*);

// ===== bench/tb_light_flicker_modulator.sv =====
module tb_light_flicker_modulator;
	import lfm_pkg::*;

	localparam logic [2:0] REG_UNUSED     = 3'd7;
	localparam logic [1:0] MODE_UNDEFINED = 2'd3;
	localparam int IDLE_PCT       = 29;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 30;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_TICKS    = 130;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index  = '0;
	logic [31:0] cfg_data   = '0;
	logic        tick_valid = 1'b0;
	logic        tick_stall;
	logic [15:0] time_step  = '0;
	logic        res_valid;
	logic        res_stall  = 1'b0;
	logic [15:0] red_out;
	logic [15:0] green_out;
	logic [15:0] blue_out;
	logic [16:0] brightness_factor;

	// Predictor state: register copy, time accumulator and the raised-cosine table.
	lfm_cfg_t          shade_cfg;
	logic [31:0]       clock_time;
	longint unsigned   pulse_rom [LFM_COS_TABLE_DEPTH];

	logic [15:0]  step_queue [$];
	lfm_result_t  colour_queue [$];

	int ticks_taken    = 0;
	int tick_mark      = 0;
	int results_seen   = 0;
	int reg_writes     = 0;
	int settings_run   = 0;
	int time_wraps     = 0;
	int errors         = 0;
	int stuck_cycles   = 0;
	int send_idle      = IDLE_PCT;
	int recv_idle      = IDLE_PCT;
	int holdoff_req    = 0;
	int holdoff_served = 0;
	int hold_left      = 0;

	light_flicker_modulator dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.tick_valid        (tick_valid),
		.tick_stall        (tick_stall),
		.time_step         (time_step),
		.res_valid         (res_valid),
		.res_stall         (res_stall),
		.red_out           (red_out),
		.green_out         (green_out),
		.blue_out          (blue_out),
		.brightness_factor (brightness_factor)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// sin^2(pi*k/D) in Q1.16, from a truncated Q30 Taylor series of the sine.
	function automatic longint unsigned sin_sq(input int k);
		longint unsigned kk, a, a2, term, s;
		longint          total;
		kk = 64'(k);
		if (LFM_COS_TABLE_DEPTH - k < k)
			kk = 64'(LFM_COS_TABLE_DEPTH - k);
		a = (PI_Q30 * kk) / LFM_COS_TABLE_DEPTH;
		a2 = (a * a) >> 30;
		term = a;
		total = a;
		for (int n = 1; n <= 6; n++) begin
			term = ((term * a2) >> 30) / 64'(2 * n * (2 * n + 1));
			if (n % 2)
				total -= term;
			else
				total += term;
		end
		if (total < 0)
			total = 0;
		if (total > ONE_Q30)
			total = ONE_Q30;
		s = total;
		return (s * s) >> 44;
	endfunction

	function automatic logic [23:0] hash_cell(input logic [31:0] x);
		x = x ^ (x >> 16);
		x = x * HASH_K1;
		x = x ^ (x >> 15);
		x = x * HASH_K2;
		x = x ^ (x >> 16);
		return x[23:0];
	endfunction

	function automatic longint unsigned noise_level(input logic [31:0] phase);
		logic [31:0]     cell_idx;
		longint unsigned f, f2, s, h0, h1;
		cell_idx = {{16{phase[31]}}, phase[31:16]};
		f = 64'(phase[15:0]);
		f2 = (f * f) >> 16;
		s = (f2 * (64'd196608 - 2 * f)) >> 16;
		h0 = 64'(hash_cell(cell_idx));
		h1 = 64'(hash_cell(cell_idx + 32'd1));
		return (h0 * (64'd65536 - s) + h1 * s) >> 24;
	endfunction

	function automatic lfm_result_t shade_tick(input logic [31:0] t, input lfm_cfg_t c);
		logic [47:0]     scaled;
		logic [31:0]     phase;
		longint unsigned d, level, factor, idx;
		lfm_result_t     r;
		scaled = {16'd0, t} * {32'd0, c.rate_scale};
		phase = scaled[39:8] + c.phase_offset;
		d = (c.depth > Q16_ONE) ? 64'd65536 : 64'(c.depth);
		case (c.anim_mode)
			MODE_FLICKER: level = noise_level(phase);
			MODE_PULSE: begin
				idx = (64'(phase[15:0]) * LFM_COS_TABLE_DEPTH) >> 16;
				if (idx >= LFM_COS_TABLE_DEPTH)
					idx = 64'(LFM_COS_TABLE_DEPTH - 1);
				level = pulse_rom[idx];
			end
			default: level = 0;
		endcase
		factor = 64'd65536 - ((d * level) >> 16);
		r.red = 16'((64'(c.base_red) * factor) >> 16);
		r.green = 16'((64'(c.base_green) * factor) >> 16);
		r.blue = 16'((64'(c.base_blue) * factor) >> 16);
		r.factor = 17'(factor);
		return r;
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
		case (idx)
			REG_ANIM_MODE:    shade_cfg.anim_mode = data[1:0];
			REG_RATE_SCALE:   shade_cfg.rate_scale = data[15:0];
			REG_PHASE_OFFSET: shade_cfg.phase_offset = data;
			REG_DEPTH:        shade_cfg.depth = data[16:0];
			REG_BASE_RED:     shade_cfg.base_red = data[15:0];
			REG_BASE_GREEN:   shade_cfg.base_green = data[15:0];
			REG_BASE_BLUE:    shade_cfg.base_blue = data[15:0];
			default: ;
		endcase
	endfunction

	function automatic void add_step(input logic [15:0] step);
		step_queue.insert(step_queue.size(), step);
	endfunction

	function automatic logic [15:0] random_level();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] random_step();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 255));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Every tick gives a result, so an empty expectation store means the block is idle.
	task automatic settle();
		while (step_queue.size() != 0 || colour_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_settings();
		logic [31:0] noise;
		logic [15:0] rate;
		logic [16:0] dep;
		logic [1:0]  mode;
		case ($urandom_range(0, 9))
			0: mode = MODE_STEADY;
			1: mode = MODE_UNDEFINED;
			2, 3, 4, 5: mode = MODE_FLICKER;
			default: mode = MODE_PULSE;
		endcase
		noise = $urandom;
		write_reg(REG_ANIM_MODE, {noise[31:2], mode});
		case ($urandom_range(0, 5))
			0: rate = 16'h0000;
			1: rate = 16'hFFFF;
			2: rate = 16'd256;
			default: rate = 16'($urandom);
		endcase
		noise = $urandom;
		write_reg(REG_RATE_SCALE, {noise[31:16], rate});
		case ($urandom_range(0, 4))
			0: noise = 32'h8000_0000;
			1: noise = 32'h7FFF_FFFF;
			default: noise = $urandom;
		endcase
		write_reg(REG_PHASE_OFFSET, noise);
		case ($urandom_range(0, 3))
			0: dep = Q16_ONE;
			1: dep = 17'($urandom);
			2: dep = 17'h1FFFF;
			default: dep = 17'($urandom_range(0, 65536));
		endcase
		noise = $urandom;
		write_reg(REG_DEPTH, {noise[31:17], dep});
		noise = $urandom;
		write_reg(REG_BASE_RED, {noise[31:16], random_level()});
		noise = $urandom;
		write_reg(REG_BASE_GREEN, {noise[31:16], random_level()});
		noise = $urandom;
		write_reg(REG_BASE_BLUE, {noise[31:16], random_level()});
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_UNUSED, $urandom);
		settings_run++;
	endtask

	task automatic random_phase(input bit quiet, input bit hold_off);
		send_idle = quiet ? 0 : IDLE_PCT;
		recv_idle = quiet ? 0 : IDLE_PCT;
		random_settings();
		repeat (PHASE_TICKS) add_step(random_step());
		if (hold_off)
			holdoff_req++;
		settle();
	endtask

	// Tick sender: holds a stalled transfer, otherwise offers the next step or idles.
	always @(negedge clk) begin
		if (!(tick_valid && ticks_taken == tick_mark)) begin
			if (step_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				tick_valid <= 1'b1;
				time_step <= step_queue[0];
				tick_mark = ticks_taken;
			end else begin
				tick_valid <= 1'b0;
			end
		end
	end

	// Result receiver, with a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else if (holdoff_served != holdoff_req) begin
			res_stall <= 1'b1;
			hold_left = HOLD_CYCLES - 1;
			holdoff_served++;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		lfm_result_t want;
		logic        carry;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				apply_reg(cfg_index, cfg_data);
				reg_writes++;
			end
			if (tick_valid && !tick_stall) begin
				{carry, clock_time} = {1'b0, clock_time} + 33'(time_step);
				time_wraps += carry;
				colour_queue.insert(colour_queue.size(), shade_tick(clock_time, shade_cfg));
				void'(step_queue.pop_front());
				ticks_taken++;
			end
			if (res_valid && !res_stall) begin
				results_seen++;
				if (colour_queue.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result %0d with no tick waiting: r %h g %h b %h f %h",
							results_seen, red_out, green_out, blue_out, brightness_factor);
				end else begin
					want = colour_queue.pop_front();
					if (red_out !== want.red || green_out !== want.green ||
						blue_out !== want.blue || brightness_factor !== want.factor) begin
						errors++;
						if (errors <= 10)
							$display("result %0d: expected r %h g %h b %h f %h, got r %h g %h b %h f %h",
								results_seen, want.red, want.green, want.blue, want.factor,
								red_out, green_out, blue_out, brightness_factor);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (tick_valid && !tick_stall) || (res_valid && !res_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", stuck_cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < LFM_COS_TABLE_DEPTH; k++)
			pulse_rom[k] = sin_sq(k);
		shade_cfg.anim_mode = MODE_STEADY;
		shade_cfg.rate_scale = 16'd256;
		shade_cfg.phase_offset = 32'd0;
		shade_cfg.depth = 17'd0;
		shade_cfg.base_red = 16'd0;
		shade_cfg.base_green = 16'd0;
		shade_cfg.base_blue = 16'd0;
		clock_time = 32'd0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset defaults: steady with black colour.
		add_step(16'h0000);
		add_step(16'hFFFF);
		settings_run++;
		settle();

		// Steady with colour extremes; the mode write carries junk in the upper bits.
		write_reg(REG_ANIM_MODE, 32'hFFFF_FFFC);
		write_reg(REG_DEPTH, 32'h0001_0000);
		write_reg(REG_BASE_RED, 32'hFFFF_FFFF);
		write_reg(REG_BASE_GREEN, 32'h0000_0000);
		write_reg(REG_BASE_BLUE, 32'h0000_5A5A);
		add_step(16'h0001);
		add_step(16'h8000);
		settings_run++;
		settle();

		// The spare mode code must act as steady; writes to the spare index are dropped.
		write_reg(REG_ANIM_MODE, 32'(MODE_UNDEFINED));
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		add_step(16'hFFFF);
		add_step(16'h1234);
		settings_run++;
		settle();

		// Flicker at top speed with depth above unity and a negative cell.
		write_reg(REG_ANIM_MODE, 32'(MODE_FLICKER));
		write_reg(REG_RATE_SCALE, 32'h0000_FFFF);
		write_reg(REG_PHASE_OFFSET, 32'h8000_0000);
		write_reg(REG_DEPTH, 32'h0001_FFFF);
		write_reg(REG_BASE_GREEN, 32'h0000_FFFF);
		add_step(16'hFFFF);
		add_step(16'h0000);
		add_step(16'h4321);
		add_step(16'hFFFF);
		settings_run++;
		settle();

		// Frozen time: the phase is the offset alone.
		write_reg(REG_RATE_SCALE, 32'h0000_0000);
		write_reg(REG_DEPTH, 32'h0000_8000);
		write_reg(REG_PHASE_OFFSET, 32'hFFFF_8000);
		add_step(16'h0000);
		settings_run++;
		settle();
		write_reg(REG_PHASE_OFFSET, 32'h7FFF_FFFF);
		add_step(16'h0000);
		settings_run++;
		settle();

		// Pulse at the start, middle and end of the cosine table.
		write_reg(REG_ANIM_MODE, 32'(MODE_PULSE));
		write_reg(REG_DEPTH, 32'h0001_0000);
		write_reg(REG_PHASE_OFFSET, 32'h0000_0000);
		add_step(16'h0000);
		settings_run++;
		settle();
		write_reg(REG_PHASE_OFFSET, 32'h0000_8000);
		add_step(16'h0000);
		settings_run++;
		settle();
		write_reg(REG_PHASE_OFFSET, 32'h0000_FFFF);
		add_step(16'h0000);
		settings_run++;
		settle();
		write_reg(REG_RATE_SCALE, 32'h0000_0100);
		add_step(16'h0040);
		add_step(16'h0040);
		add_step(16'h0040);
		add_step(16'hFFC0);
		settings_run++;
		settle();

		random_phase(1'b0, 1'b0);
		random_phase(1'b1, 1'b0);
		random_phase(1'b0, 1'b1);
		random_phase(1'b0, 1'b0);
		random_phase(1'b0, 1'b0);
		random_phase(1'b0, 1'b1);
		random_phase(1'b1, 1'b0);
		random_phase(1'b0, 1'b0);

		$display("checked %0d results from %0d ticks under %0d settings (%0d register writes)",
			results_seen, ticks_taken, settings_run, reg_writes);
		$display("time accumulator wrapped %0d time(s); %0d mismatches", time_wraps, errors);
		if (errors == 0 && colour_queue.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
